@@ hdl/lfd_pkg.sv @@
// ----------------------------------------------------------------------------
// LED fade dimmer package
// Types, register and operation codes, and the constant-divisor helpers
// shared by the dimmer modules.
// ----------------------------------------------------------------------------
package lfd_pkg;

  localparam int unsigned PctWidth   = 16;
  localparam int unsigned LevelWidth = 8;
  localparam int unsigned CfgWidth   = 16;
  localparam int unsigned CountWidth = 32;
  localparam int unsigned InDataW    = 16;
  localparam int unsigned InUserW    = 2;
  localparam int unsigned OutDataW   = 24;
  localparam int unsigned OutUserW   = 1;

  // Percentages above this value give full brightness.
  localparam logic signed [PctWidth-1:0] PctFullScale = 16'sd100;
  localparam logic [LevelWidth-1:0]      LevelMax     = 8'd255;

  // percent * 255 / 100 is done as (percent * PctRecip) >> 19, where PctRecip
  // sits a little above 255 * 2^19 / 100 so that products which divide out
  // exactly are not floored one short. This is exact for every percentage
  // from 0 to 100.
  localparam logic [20:0] PctRecip = 21'd1336965;
  localparam int unsigned PctShift = 19;

  typedef enum logic [1:0] {
    OP_SET_LEVEL  = 2'd0,
    OP_FADE_TICK  = 2'd1,
    OP_TIMER_TICK = 2'd2
  } op_e;

  typedef enum logic {
    REG_TIMEOUT_SECONDS   = 1'b0,
    REG_CYCLES_PER_SECOND = 1'b1
  } reg_idx_e;

  typedef struct packed {
    op_e                         op;
    logic signed [PctWidth-1:0]  percent;
  } item_t;

  typedef struct packed {
    logic [CfgWidth-1:0] timeout_seconds;
    logic [CfgWidth-1:0] cycles_per_second;
  } cfg_t;

  // A write to the timeout register reloads the countdown with the new value times cycles_per_second.
  typedef struct packed {
    logic                reload;
    logic [CfgWidth-1:0] timeout_seconds;
  } cfg_wr_t;

  typedef struct packed {
    logic [LevelWidth-1:0] target_level;
    logic [LevelWidth-1:0] current_level;
    logic                  duty_written;
    logic [LevelWidth-1:0] pwm_duty;
  } result_t;

  // Clamp a signed percentage and scale it to a brightness of 0 to 255.
  function automatic logic [LevelWidth-1:0] pct_to_level(logic signed [PctWidth-1:0] pct);
    logic [27:0] prod;
    prod = 28'(pct[6:0]) * 28'(PctRecip);
    if (pct < 16'sd0) begin
      return '0;
    end else if (pct > PctFullScale) begin
      return LevelMax;
    end
    return prod[PctShift+LevelWidth-1:PctShift];
  endfunction

  // level * level / 255, using x / 255 = (x + (x >> 8) + 1) >> 8 for x <= 255 * 255.
  function automatic logic [LevelWidth-1:0] square_div255(logic [LevelWidth-1:0] lvl);
    logic [15:0] sq;
    logic [16:0] sum;
    sq  = 16'(lvl) * 16'(lvl);
    sum = 17'(sq) + 17'(sq[15:8]) + 17'd1;
    return sum[15:8];
  endfunction

endpackage

@@ hdl/lfd_in_stage.sv @@
// ----------------------------------------------------------------------------
// LED fade dimmer input stage
// Registers one accepted transaction and holds it while the result side stalls.
// ----------------------------------------------------------------------------
module lfd_in_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  lfd_pkg::item_t item_i,
  input  logic           advance_i,
  output logic           valid_o,
  output lfd_pkg::item_t item_o
);

  logic           valid_d, valid_q;
  lfd_pkg::item_t item_q;

  // The held item leaves whenever the engine advances.
  assign ready_o = !valid_q || advance_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

@@ hdl/lfd_engine.sv @@
// ----------------------------------------------------------------------------
// LED fade dimmer engine
// Holds the brightness state, applies one item per cycle while the result side
// is not stalled, and registers the result transaction.
// ----------------------------------------------------------------------------
module lfd_engine (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lfd_pkg::cfg_t    cfg_i,
  input  lfd_pkg::cfg_wr_t cfg_wr_i,
  input  logic             item_valid_i,
  input  lfd_pkg::item_t   item_i,
  input  logic             advance_i,
  output logic             valid_o,
  output lfd_pkg::result_t result_o
);

  logic [lfd_pkg::LevelWidth-1:0] target_d, target_q;
  logic [lfd_pkg::LevelWidth-1:0] level_d, level_q;
  logic [lfd_pkg::LevelWidth-1:0] duty_d, duty_q;
  logic [lfd_pkg::CountWidth-1:0] countdown_d, countdown_q;
  logic [lfd_pkg::CfgWidth-1:0]   mul_a;
  logic [lfd_pkg::CountWidth-1:0] reload_value;
  logic                           fire;
  logic                           wrote;
  logic                           valid_d, valid_q;
  lfd_pkg::result_t               result_d, result_q;

  assign fire = item_valid_i && advance_i;

  // A timeout write uses the incoming value; otherwise the stored one.
  assign mul_a = cfg_wr_i.reload ? cfg_wr_i.timeout_seconds : cfg_i.timeout_seconds;
  assign reload_value = 32'(mul_a) * 32'(cfg_i.cycles_per_second);

  always_comb begin
    target_d    = target_q;
    level_d     = level_q;
    duty_d      = duty_q;
    countdown_d = countdown_q;
    wrote       = 1'b0;
    if (cfg_wr_i.reload) begin
      countdown_d = reload_value;
    end
    if (fire) begin
      case (item_i.op)
        lfd_pkg::OP_SET_LEVEL: begin
          target_d    = lfd_pkg::pct_to_level(item_i.percent);
          countdown_d = reload_value;
        end
        lfd_pkg::OP_FADE_TICK: begin
          if (level_q != target_q) begin
            level_d = (level_q < target_q) ? level_q + 8'd1 : level_q - 8'd1;
            duty_d  = lfd_pkg::square_div255(level_d);
            wrote   = 1'b1;
          end
        end
        lfd_pkg::OP_TIMER_TICK: begin
          if (cfg_i.timeout_seconds != '0) begin
            if (countdown_q != '0) begin
              countdown_d = countdown_q - 32'd1;
            end else begin
              // Timeout expired: the fallback percentage becomes the target.
              target_d    = lfd_pkg::pct_to_level(item_i.percent);
              countdown_d = reload_value;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    result_d.pwm_duty      = duty_d;
    result_d.duty_written  = wrote;
    result_d.current_level = level_d;
    result_d.target_level  = target_d;
  end

  assign valid_d = advance_i ? fire : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q    <= '0;
      level_q     <= '0;
      duty_q      <= '0;
      countdown_q <= '0;
      valid_q     <= 1'b0;
    end else begin
      target_q    <= target_d;
      level_q     <= level_d;
      duty_q      <= duty_d;
      countdown_q <= countdown_d;
      valid_q     <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      result_q <= result_d;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

@@ hdl/led_fade_dimmer_core.sv @@
// ----------------------------------------------------------------------------
// LED fade dimmer core
// Fading LED brightness controller with square-law duty and fallback timeout.
// ----------------------------------------------------------------------------
// The dimmer takes one transaction per clock cycle while the output side keeps
// up, and returns exactly one result transaction for each, in order. A
// transaction passes through an input register and then a result register;
// its result is offered from the result register until the output side takes
// it. The single-cycle rate is set by the step logic between those two
// registers (one 16 by 16 bit countdown product, one small constant multiply
// for the percentage scaling and one 8 bit square). When the output stalls,
// the result register holds and the input register can still take one more
// transaction; s_axis_tready falls only while both are full and m_axis_tready
// is low. Set-level transactions clamp the percentage (negative gives 0, above
// 100 gives 255) and reload the countdown with timeout_seconds times
// cycles_per_second; fade ticks step the current level one towards the target
// and, if it moved, write a new duty of level squared over 255 and flag it;
// timer ticks count the countdown down and apply their percentage when it has
// reached zero, unless the timeout is zero. The user must write configuration
// through the cfg port only while the block is idle; the block does not enforce
// this. Writing the timeout register also reloads the countdown.
// ----------------------------------------------------------------------------
module led_fade_dimmer_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write port.
  input  logic                           cfg_we_i,
  input  logic                           cfg_idx_i,
  input  logic [lfd_pkg::CfgWidth-1:0]   cfg_wdata_i,
  // Input stream.
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [lfd_pkg::InDataW-1:0]    s_axis_tdata,   // [15:0] percent (signed)
  input  logic [lfd_pkg::InUserW-1:0]    s_axis_tuser,   // [1:0] op
  // Result stream.
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [lfd_pkg::OutDataW-1:0]   m_axis_tdata,   // [7:0] pwm_duty,
                                                         // [15:8] current_level,
                                                         // [23:16] target_level
  output logic [lfd_pkg::OutUserW-1:0]   m_axis_tuser    // [0] duty_written
);

  logic [lfd_pkg::CfgWidth-1:0] timeout_seconds_q;
  logic [lfd_pkg::CfgWidth-1:0] cycles_per_second_q;
  lfd_pkg::cfg_t                cfg;
  lfd_pkg::cfg_wr_t             cfg_wr;
  lfd_pkg::item_t               in_item;
  lfd_pkg::item_t               held_item;
  lfd_pkg::result_t             result;
  logic                         held_valid;
  logic                         advance;
  logic                         reg_timeout_sel;
  logic                         reg_cps_sel;

  // Configuration registers. The index is decoded through its named codes.
  assign reg_timeout_sel = cfg_we_i &&
                           (lfd_pkg::reg_idx_e'(cfg_idx_i) == lfd_pkg::REG_TIMEOUT_SECONDS);
  assign reg_cps_sel     = cfg_we_i &&
                           (lfd_pkg::reg_idx_e'(cfg_idx_i) == lfd_pkg::REG_CYCLES_PER_SECOND);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_seconds_q   <= '0;
      cycles_per_second_q <= '0;
    end else begin
      if (reg_timeout_sel) begin
        timeout_seconds_q <= cfg_wdata_i;
      end
      if (reg_cps_sel) begin
        cycles_per_second_q <= cfg_wdata_i;
      end
    end
  end

  assign cfg.timeout_seconds    = timeout_seconds_q;
  assign cfg.cycles_per_second  = cycles_per_second_q;
  assign cfg_wr.reload          = reg_timeout_sel;
  assign cfg_wr.timeout_seconds = cfg_wdata_i;

  // The whole pipeline moves whenever the result register is free or drains.
  assign advance = !m_axis_tvalid || m_axis_tready;

  assign in_item.op      = lfd_pkg::op_e'(s_axis_tuser);
  assign in_item.percent = s_axis_tdata;

  lfd_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid),
    .ready_o   (s_axis_tready),
    .item_i    (in_item),
    .advance_i (advance),
    .valid_o   (held_valid),
    .item_o    (held_item)
  );

  lfd_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .cfg_wr_i     (cfg_wr),
    .item_valid_i (held_valid),
    .item_i       (held_item),
    .advance_i    (advance),
    .valid_o      (m_axis_tvalid),
    .result_o     (result)
  );

  assign m_axis_tdata = {result.target_level, result.current_level, result.pwm_duty};
  assign m_axis_tuser = result.duty_written;

`ifndef ASSERT_OFF
  // Input back-pressure only ever comes from a stalled, full result side.
  a_ready_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled while the result side could move");

  // A held transaction that advances always turns into a result.
  a_item_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_valid && advance) |=> m_axis_tvalid)
    else $error("advanced transaction produced no result");

  // A result that was not taken stays offered.
  a_result_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");
`endif

endmodule
